// ===== rtl/core/tphc_pkg.sv =====
// ----------------------------------------------------------------------------
// tphc_pkg
// Shared types, register indexes and ones' complement helpers for the
// transport pseudo header checksum block.
// ----------------------------------------------------------------------------
`default_nettype none

package tphc_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam logic [CfgIdxWidth-1:0] CfgSrcAddr  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgDstAddr  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgProtocol = 2'd2;

  // register reset values
  localparam logic [31:0] SrcAddrReset  = 32'h0000_0000;
  localparam logic [31:0] DstAddrReset  = 32'h0000_0000;
  localparam logic [7:0]  ProtocolReset = 8'd17;

  localparam logic [15:0] WordMask = 16'hffff;

  // segment sum and length handed from the byte accumulator to the finish stage
  typedef struct packed {
    logic        valid;
    logic [15:0] sum;
    logic [15:0] len;
  } tphc_fin_t;

  // two-operand ones' complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // fold a multi-operand sum (up to eight words) back to 16 bits
  function automatic logic [15:0] fold19(input logic [18:0] s);
    logic [16:0] t;
    t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/transport_pseudo_header_checksum.sv =====
// ----------------------------------------------------------------------------
// transport_pseudo_header_checksum
// TCP/UDP checksum over an IPv4 pseudo header and a byte-streamed segment.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                    | beat
//  ---------+--------------------------------------------+--------------------
//  in       | in_valid_i, in_stall_o, data_byte_i,       | one segment byte
//           | last_byte_i                                |
//  out      | out_valid_o, out_stall_i,                  | checksum and length
//           | checksum_value_o, segment_length_o         | per segment
//  cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i           | one register write
//
//  one byte is taken per cycle while in_stall_o is low; the byte pair adder
//  closes a word on every second byte
//  a result passes the handoff register, then the pseudo add into the result register
//  one finished segment may wait in the handoff register behind a stalled
//  result, so input stalls only when both are full and out is stalled
//  reset clears the segment state and loads the register defaults
//
`default_nettype none

module transport_pseudo_header_checksum (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [tphc_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  wire logic [tphc_pkg::CfgDataWidth-1:0]      cfg_wdata_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [7:0]                             data_byte_i,
  input  wire logic                                   last_byte_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [15:0]                                 checksum_value_o,
  output logic [15:0]                                 segment_length_o
);
  import tphc_pkg::*;

  tphc_fin_t fin;
  logic      fin_advance;

  // byte pairing and running sum
  tphc_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .fin_advance_i (fin_advance),
    .fin_o         (fin)
  );

  // pseudo header add and result register
  tphc_finish u_finish (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .fin_i            (fin),
    .fin_advance_o    (fin_advance),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .checksum_value_o (checksum_value_o),
    .segment_length_o (segment_length_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tphc_accum.sv =====
// ----------------------------------------------------------------------------
// tphc_accum
// Pairs segment bytes into big-endian words, keeps the running ones'
// complement sum and byte count, and hands the padded sum to the finish stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tphc_accum (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  input  wire logic             fin_advance_i,
  output tphc_pkg::tphc_fin_t   fin_o
);
  import tphc_pkg::*;

  logic [15:0] sum_q, sum_d;
  logic [7:0]  held_q, held_d;
  logic        odd_q, odd_d;
  logic [15:0] count_q, count_d;
  logic        fin_valid_q, fin_valid_d;
  logic [15:0] fin_sum_q, fin_len_q;

  logic        accept;
  logic [15:0] word;
  logic [15:0] sum_new;
  logic [15:0] count_new;

  // a finished sum occupies the handoff register until the finish stage takes it
  assign in_stall_o = fin_valid_q && !fin_advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // completed word from the held byte and this byte, or this byte padded with a zero low byte
  assign word      = odd_q ? {held_q, data_byte_i} : {data_byte_i, 8'h00};
  assign sum_new   = ones_add(sum_q, word);
  assign count_new = count_q + 16'd1;

  // next state for pairing, sum and count
  always_comb begin
    sum_d   = sum_q;
    held_d  = held_q;
    odd_d   = odd_q;
    count_d = count_q;
    if (accept) begin
      if (last_byte_i) begin
        sum_d   = '0;
        held_d  = '0;
        odd_d   = 1'b0;
        count_d = '0;
      end else if (odd_q) begin
        sum_d   = sum_new;
        held_d  = '0;
        odd_d   = 1'b0;
        count_d = count_new;
      end else begin
        held_d  = data_byte_i;
        odd_d   = 1'b1;
        count_d = count_new;
      end
    end
  end

  assign fin_valid_d = (accept && last_byte_i) || (fin_valid_q && !fin_advance_i);

  // accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      held_q      <= '0;
      odd_q       <= 1'b0;
      count_q     <= '0;
      fin_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      held_q      <= held_d;
      odd_q       <= odd_d;
      count_q     <= count_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  // handoff payload, loaded on the last beat of a segment
  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      fin_sum_q <= sum_new;
      fin_len_q <= count_new;
    end
  end

  assign fin_o = '{valid: fin_valid_q, sum: fin_sum_q, len: fin_len_q};

  // held byte is clear whenever no word is half built
  a_held_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !odd_q |-> held_q == 8'h00)
    else $error("held byte not cleared outside odd phase");

  // last beat leaves the segment state empty and a sum in the handoff register
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |=> fin_valid_q && count_q == 16'd0 && sum_q == 16'd0 && !odd_q)
    else $error("segment state not cleared after last beat");

  // a non-last beat advances the count by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !last_byte_i |=> count_q == $past(count_q) + 16'd1)
    else $error("byte count did not advance");

endmodule

`default_nettype wire

// ===== rtl/core/tphc_finish.sv =====
// ----------------------------------------------------------------------------
// tphc_finish
// Holds the configuration registers and their pseudo header sum, adds the
// pseudo header and length to a finished segment sum and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tphc_finish (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [tphc_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  wire logic [tphc_pkg::CfgDataWidth-1:0]      cfg_wdata_i,
  input  wire tphc_pkg::tphc_fin_t                    fin_i,
  output logic                                        fin_advance_o,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [15:0]                                 checksum_value_o,
  output logic [15:0]                                 segment_length_o
);
  import tphc_pkg::*;

  logic [31:0] src_q;
  logic [31:0] dst_q;
  logic [7:0]  proto_q;
  logic [15:0] pseudo_q, pseudo_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] csum_q, len_q;
  logic [15:0] total;

  // configuration registers, out-of-range index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= SrcAddrReset;
      dst_q   <= DstAddrReset;
      proto_q <= ProtocolReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSrcAddr:  src_q   <= cfg_wdata_i;
        CfgDstAddr:  dst_q   <= cfg_wdata_i;
        CfgProtocol: proto_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // pseudo header words folded once per cycle from the registers
  assign pseudo_d = fold19({3'd0, src_q[31:16]} + {3'd0, src_q[15:0]} +
                           {3'd0, dst_q[31:16]} + {3'd0, dst_q[15:0]} +
                           {11'd0, proto_q});

  // segment sum plus pseudo header plus length
  assign total = fold19({3'd0, fin_i.sum} + {3'd0, pseudo_q} + {3'd0, fin_i.len});

  // result register drains or refills
  assign fin_advance_o = !out_valid_q || !out_stall_i;
  assign out_valid_d   = fin_i.valid || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pseudo_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pseudo_q    <= pseudo_d;
      if (fin_advance_o) begin
        out_valid_q <= out_valid_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fin_advance_o && fin_i.valid) begin
      csum_q <= ~total & WordMask;
      len_q  <= fin_i.len;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign checksum_value_o = csum_q;
  assign segment_length_o = len_q;

  // a finished sum is never dropped: it moves to the result or stays pending
  a_fin_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_i.valid && fin_advance_o |=> out_valid_q && len_q == $past(fin_i.len))
    else $error("finished sum lost on handoff");

  // a pending result blocks the handoff only while it is stalled
  a_adv_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fin_advance_o |-> out_valid_q && out_stall_i)
    else $error("handoff blocked without a stalled result");

  // protocol write reaches its register
  a_cfg_proto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == CfgProtocol |=> proto_q == $past(cfg_wdata_i[7:0]))
    else $error("protocol write not taken");

endmodule

`default_nettype wire

// ===== bench/transport_pseudo_header_checksum_tb.sv =====
// ----------------------------------------------------------------------------
// transport_pseudo_header_checksum_tb
// Streams segment bytes through the checksum block and compares every
// checksum and length beat with a local model of the ones' complement sum.
// Runs a table of hand-checked segments, segments at the
// register extremes, random segments under sender and receiver idling,
// and a long receiver hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------

module transport_pseudo_header_checksum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tphc_pkg::*;

  localparam logic [CfgIdxWidth-1:0] CfgIdxUnused = 2'd3;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LongHold = 250;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned NumDirected = 21;

  typedef struct {
    logic [15:0] csum;
    logic [15:0] len;
  } seg_result_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    bit          typed;
    logic [15:0] csum;
    logic [15:0] len;
  } byte_row_t;

  // dut ports
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i = '0;
  logic [CfgDataWidth-1:0] cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [7:0]              data_byte_i = '0;
  logic                    last_byte_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [15:0]             checksum_value_o;
  logic [15:0]             segment_length_o;

  // model copy of the registers and the segment state
  logic [31:0] cfg_src = SrcAddrReset;
  logic [31:0] cfg_dst = DstAddrReset;
  logic [7:0]  cfg_proto = ProtocolReset;
  logic [15:0] seg_sum = '0;
  logic [7:0]  hi_byte = '0;
  logic        hi_pending = 1'b0;
  logic [15:0] seg_bytes = '0;

  seg_result_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  byte_row_t   dir_rows[NumDirected];

  transport_pseudo_header_checksum u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .checksum_value_o (checksum_value_o),
    .segment_length_o (segment_length_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ones' complement add, carry wrapped back in
  function automatic logic [15:0] wrap_add16(input logic [15:0] a, input logic [15:0] b);
    int unsigned s;
    s = int'(a) + int'(b);
    if (s > 32'h0000_ffff) s = s - 32'h0000_ffff;
    return s[15:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at %0t: %s got %04h want %04h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // model one accepted byte; a last byte closes the segment and queues its result
  task automatic absorb_byte(input logic [7:0] d, input logic l, input bit typed,
                             input logic [15:0] t_csum, input logic [15:0] t_len);
    logic [15:0] total;
    seg_bytes = seg_bytes + 16'd1;
    if (hi_pending) begin
      seg_sum = wrap_add16(seg_sum, {hi_byte, d});
      hi_byte = '0;
      hi_pending = 1'b0;
    end else begin
      hi_byte = d;
      hi_pending = 1'b1;
    end
    if (l) begin
      total = seg_sum;
      // odd length: pad the held byte with a zero low byte
      if (hi_pending) total = wrap_add16(total, {hi_byte, 8'h00});
      total = wrap_add16(total, cfg_src[31:16]);
      total = wrap_add16(total, cfg_src[15:0]);
      total = wrap_add16(total, cfg_dst[31:16]);
      total = wrap_add16(total, cfg_dst[15:0]);
      total = wrap_add16(total, {8'h00, cfg_proto});
      total = wrap_add16(total, seg_bytes);
      if (typed) pending_results.push_back('{csum: t_csum, len: t_len});
      else pending_results.push_back('{csum: ~total, len: seg_bytes});
      seg_sum = '0;
      hi_byte = '0;
      hi_pending = 1'b0;
      seg_bytes = '0;
    end
  endtask

  // offer one beat after a random gap and hold it until taken
  task automatic send_beat(input logic [7:0] d, input logic l, input bit typed = 1'b0,
                           input logic [15:0] t_csum = '0, input logic [15:0] t_len = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    absorb_byte(d, l, typed, t_csum, t_len);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgSrcAddr:  cfg_src = val;
      CfgDstAddr:  cfg_dst = val;
      CfgProtocol: cfg_proto = val[7:0];
      default: ;
    endcase
  endtask

  // all three registers, plus a write to the unused index that must be dropped
  task automatic load_config(input logic [31:0] src, input logic [31:0] dst,
                             input logic [7:0] proto);
    write_reg(CfgSrcAddr, src);
    write_reg(CfgIdxUnused, $urandom);
    write_reg(CfgDstAddr, dst);
    write_reg(CfgProtocol, {16'($urandom_range(16'hffff, 0)), 8'($urandom_range(255, 0)),
                            proto});
    cfg_we_i <= 1'b0;
  endtask

  // stop offering until every queued result has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_seg_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(16, 1);
    if (r < 95) return $urandom_range(120, 17);
    return $urandom_range(600, 121);
  endfunction

  // random segments until n bytes have gone in
  task automatic run_segments(input int unsigned n);
    int unsigned sent;
    int unsigned seg_len;
    sent = 0;
    while (sent < n) begin
      seg_len = pick_seg_len();
      if (seg_len > n - sent) seg_len = n - sent;
      for (int unsigned k = 1; k <= seg_len; k++)
        send_beat(8'($urandom_range(255)), k == seg_len);
      sent += seg_len;
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  // receiver: random stalls, or a long counted hold when one is asked for
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      out_stall_i <= 1'b1;
      hold_left   <= LongHold - 1;
      hold_served <= hold_asks;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    seg_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, checksum", checksum_value_o, 16'h0000);
      end else begin
        want = pending_results.pop_front();
        if (checksum_value_o !== want.csum)
          report_mismatch("checksum_value", checksum_value_o, want.csum);
        if (segment_length_o !== want.len)
          report_mismatch("segment_length", segment_length_o, want.len);
      end
    end
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("transport_pseudo_header_checksum_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    // hand-checked rows assume the reset registers: addresses zero, protocol 17
    dir_rows = '{
      '{8'h00, 1'b1, 1'b1, 16'hffed, 16'd1},
      '{8'hff, 1'b1, 1'b1, 16'h00ed, 16'd1},
      '{8'hff, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'hec, 1'b1, 1'b1, 16'h0000, 16'd2},  // sum is all ones, checksum zero
      '{8'hff, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'hff, 1'b1, 1'b1, 16'hffec, 16'd2},
      '{8'h80, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'h01, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'h7f, 1'b1, 1'b1, 16'h00ea, 16'd3},  // odd length, padded
      '{8'h01, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'h02, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'h04, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'h08, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'h10, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'h20, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'h40, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'h80, 1'b1, 1'b0, 16'h0000, 16'd0},
      '{8'h55, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'haa, 1'b1, 1'b0, 16'h0000, 16'd0},
      '{8'h00, 1'b0, 1'b0, 16'h0000, 16'd0},
      '{8'h00, 1'b1, 1'b1, 16'hffec, 16'd2}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under reset registers
    send_idle_pct  = 33;
    recv_stall_pct = 68;
    foreach (dir_rows[i])
      send_beat(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].csum, dir_rows[i].len);
    settle();

    // all-zero registers: four zero bytes leave only the length in the sum
    load_config(32'h0000_0000, 32'h0000_0000, 8'h00);
    for (int unsigned k = 1; k <= 4; k++)
      send_beat(8'h00, k == 4, k == 4, 16'hfffb, 16'd4);
    settle();

    // all-ones registers
    send_idle_pct  = 33;
    recv_stall_pct = 68;
    load_config(32'hffff_ffff, 32'hffff_ffff, 8'hff);
    run_segments(200);
    settle();

    // random registers, sender idles less than receiver
    load_config($urandom, $urandom, 8'($urandom_range(255)));
    run_segments(500);
    settle();

    // random registers, roles swapped
    send_idle_pct  = 68;
    recv_stall_pct = 33;
    load_config($urandom, $urandom, 8'($urandom_range(255)));
    run_segments(500);
    settle();

    // long receiver hold while one-byte segments keep coming, fills the block
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asks++;
    for (int k = 0; k < 40; k++)
      send_beat(8'($urandom_range(255)), 1'b1);
    settle();

    // random registers, no idling
    load_config($urandom, $urandom, 8'($urandom_range(255)));
    run_segments(500);
    settle();

    if (mismatch_count == 0) begin
      $display("transport_pseudo_header_checksum_tb passed");
    end else begin
      $display("transport_pseudo_header_checksum_tb failed");
    end
    $finish;
  end

endmodule
